### rtl/core/prm_pkg.sv
// Shared widths for the permutation ranking block.
`timescale 1ns / 1ps
`default_nettype none
package prm_pkg;

   localparam int PACK_W  = 48;   // packed element vector on the request port
   localparam int COUNT_W = 4;    // element count field
   localparam int ORD_W   = 29;   // ordinal field, holds 12!-1

endpackage
`default_nettype wire

### rtl/core/prm_lane.sv
// One comparison lane: flags its element as the first maximum over 0..limit.
`timescale 1ns / 1ps
`default_nettype none
module prm_lane import prm_pkg::*; #(
   parameter int LANE_IDX   = 0,
   parameter int MAX_ELEMS  = 12,
   parameter int ELEM_WIDTH = 4,
   parameter int LIM_W      = $clog2(MAX_ELEMS)
) (
   input  wire logic [MAX_ELEMS*ELEM_WIDTH-1:0] elems,
   input  wire logic [LIM_W-1:0]                limit,
   output logic                                 hit
);

   logic [ELEM_WIDTH-1:0] own;
   logic [MAX_ELEMS-1:0]  wins;

   assign own = elems[LANE_IDX*ELEM_WIDTH +: ELEM_WIDTH];

   // lower positions must be smaller, higher ones inside the window must not exceed us
   always_comb begin
      for (int j = 0; j < MAX_ELEMS; j++) begin
         if (j < LANE_IDX) begin
            wins[j] = own > elems[j*ELEM_WIDTH +: ELEM_WIDTH];
         end else if (j == LANE_IDX) begin
            wins[j] = 1'b1;
         end else begin
            wins[j] = (LIM_W'(j) > limit) || (own >= elems[j*ELEM_WIDTH +: ELEM_WIDTH]);
         end
      end
   end

   assign hit = (LIM_W'(LANE_IDX) <= limit) && (&wins);

endmodule
`default_nettype wire

### rtl/core/prm_merge.sv
// Merge stage: encodes the winning lane, folds it into the ordinal, swaps elements.
`timescale 1ns / 1ps
`default_nettype none
module prm_merge import prm_pkg::*; #(
   parameter int MAX_ELEMS  = 12,
   parameter int ELEM_WIDTH = 4,
   parameter int LIM_W      = $clog2(MAX_ELEMS)
) (
   input  wire logic [MAX_ELEMS*ELEM_WIDTH-1:0] elems,
   input  wire logic [LIM_W-1:0]                limit,
   input  wire logic [MAX_ELEMS-1:0]            hits,
   input  wire logic [ORD_W-1:0]                rank,
   output logic [MAX_ELEMS*ELEM_WIDTH-1:0]      elems_next,
   output logic [ORD_W-1:0]                     rank_next
);

   logic [LIM_W-1:0]      pos;
   logic [ELEM_WIDTH-1:0] at_pos;
   logic [ELEM_WIDTH-1:0] at_lim;
   logic [LIM_W:0]        radix;
   logic [ORD_W-1:0]      scaled;

   // exactly one lane hits, so OR-reduction acts as an encoder and a mux
   always_comb begin
      pos    = '0;
      at_pos = '0;
      at_lim = '0;
      for (int i = 0; i < MAX_ELEMS; i++) begin
         if (hits[i]) begin
            pos    = pos | LIM_W'(i);
            at_pos = at_pos | elems[i*ELEM_WIDTH +: ELEM_WIDTH];
         end
         if (LIM_W'(i) == limit) begin
            at_lim = elems[i*ELEM_WIDTH +: ELEM_WIDTH];
         end
      end
   end

   assign radix     = {1'b0, limit} + 1'b1;
   assign scaled    = rank * ORD_W'(radix);
   assign rank_next = scaled + ORD_W'(pos);

   always_comb begin
      for (int k = 0; k < MAX_ELEMS; k++) begin
         if (LIM_W'(k) == limit) begin
            elems_next[k*ELEM_WIDTH +: ELEM_WIDTH] = at_pos;
         end else if (LIM_W'(k) == pos) begin
            elems_next[k*ELEM_WIDTH +: ELEM_WIDTH] = at_lim;
         end else begin
            elems_next[k*ELEM_WIDTH +: ELEM_WIDTH] = elems[k*ELEM_WIDTH +: ELEM_WIDTH];
         end
      end
   end

endmodule
`default_nettype wire

### rtl/core/permutation_rank.sv
// Top level of the permutation ranking block (factorial number system).
//
//   channel   signals                                   handshake
//   request   req_perm_packed, req_elem_count           start && !busy
//   response  rsp_ordinal                               rsp_strobe, one cycle
//
// An item with n elements (count saturated at MAX_ELEMS) takes one step per limit,
// from n-1 down to 1; each step is the lane compare, encode, multiply-add and swap
// that form the loop from the element register back to itself.
// The result strobes in the cycle after the last step; busy drops then, so
// the next transaction may start in that same cycle.
// Synchronous reset clears the busy and strobe flags. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module permutation_rank import prm_pkg::*; #(
   parameter int MAX_ELEMS  = 12,
   parameter int ELEM_WIDTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [PACK_W-1:0]  req_perm_packed,
   input  wire logic [COUNT_W-1:0] req_elem_count,
   output logic                    rsp_strobe,
   output logic [ORD_W-1:0]        rsp_ordinal
);

   localparam int LIM_W  = $clog2(MAX_ELEMS);
   localparam int VEC_W  = MAX_ELEMS * ELEM_WIDTH;
   localparam int EXT_W  = PACK_W + VEC_W;

   logic                 run_ff, run_in;
   logic                 strobe_ff, strobe_in;
   logic [VEC_W-1:0]     work_ff, work_in;
   logic [LIM_W-1:0]     lim_ff, lim_in;
   logic [ORD_W-1:0]     rank_ff, rank_in;
   logic [ORD_W-1:0]     ord_ff, ord_in;

   logic                 accept;
   logic [COUNT_W-1:0]   count_sat;
   logic [LIM_W-1:0]     lim_start;
   logic [EXT_W-1:0]     packed_ext;
   logic [MAX_ELEMS-1:0] hits;
   logic [VEC_W-1:0]     work_step;
   logic [ORD_W-1:0]     rank_step;

   assign accept     = start && !run_ff;
   assign count_sat  = (req_elem_count > COUNT_W'(MAX_ELEMS)) ? COUNT_W'(MAX_ELEMS)
                                                              : req_elem_count;
   assign lim_start  = (count_sat == '0) ? '0 : LIM_W'(count_sat - 1'b1);
   // elements past the packed input read as zero
   assign packed_ext = {{VEC_W{1'b0}}, req_perm_packed};

   for (genvar g = 0; g < MAX_ELEMS; g++) begin : g_lane
      prm_lane #(
         .LANE_IDX  (g),
         .MAX_ELEMS (MAX_ELEMS),
         .ELEM_WIDTH(ELEM_WIDTH),
         .LIM_W     (LIM_W)
      ) u_lane (
         .elems(work_ff),
         .limit(lim_ff),
         .hit  (hits[g])
      );
   end

   prm_merge #(
      .MAX_ELEMS (MAX_ELEMS),
      .ELEM_WIDTH(ELEM_WIDTH),
      .LIM_W     (LIM_W)
   ) u_merge (
      .elems     (work_ff),
      .limit     (lim_ff),
      .hits      (hits),
      .rank      (rank_ff),
      .elems_next(work_step),
      .rank_next (rank_step)
   );

   always_comb begin
      run_in    = run_ff;
      strobe_in = 1'b0;
      work_in   = work_ff;
      lim_in    = lim_ff;
      rank_in   = rank_ff;
      ord_in    = ord_ff;
      if (run_ff) begin
         work_in = work_step;
         rank_in = rank_step;
         lim_in  = lim_ff - 1'b1;
         if (lim_ff == LIM_W'(1)) begin
            run_in    = 1'b0;
            strobe_in = 1'b1;
            ord_in    = rank_step;
         end
      end else if (accept) begin
         work_in = packed_ext[VEC_W-1:0];
         lim_in  = lim_start;
         rank_in = '0;
         if (lim_start == '0) begin
            // zero or one element: rank is zero, no steps needed
            strobe_in = 1'b1;
            ord_in    = '0;
         end else begin
            run_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         run_ff    <= run_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      lim_ff  <= lim_in;
      rank_ff <= rank_in;
      ord_ff  <= ord_in;
   end

   assign busy        = run_ff;
   assign rsp_strobe  = strobe_ff;
   assign rsp_ordinal = ord_ff;

endmodule
`default_nettype wire

### rtl/core/prm_checker.sv
// Port-level checker for the permutation ranking block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module prm_checker import prm_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic [COUNT_W-1:0] req_elem_count,
   input wire logic               rsp_strobe,
   input wire logic [ORD_W-1:0]   rsp_ordinal
);

   // a response never overlaps work in flight
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobed while busy");

   // every accepted transaction either starts work or answers at once
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted transaction went nowhere");

   // finishing work always produces a response
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a response");

   // short vectors rank as zero in the next cycle
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_elem_count == COUNT_W'(0) || req_elem_count == COUNT_W'(1)))
      |=> (rsp_strobe && rsp_ordinal == '0))
      else $error("short vector did not rank as zero");

   // responses stay within 12!-1
   a_ord_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_ordinal < ORD_W'(479001600)))
      else $error("ordinal out of range");

endmodule

bind permutation_rank prm_checker u_prm_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_elem_count(req_elem_count),
   .rsp_strobe    (rsp_strobe),
   .rsp_ordinal   (rsp_ordinal)
);
`default_nettype wire
